/* rtl/core/dscv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dscv_pkg
// Types, tables and helper functions for the diatonic seventh chord voicer.
// ----------------------------------------------------------------------------

package dscv_pkg;

    localparam int NOTE_W = 7;
    localparam int DEG_W  = 8;
    localparam int CFG_W  = 6;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_SCALE_MODE      = 2'd0;
    localparam logic [IDX_W-1:0] CFG_INVERSION_SEL   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_VOICING_SEL     = 2'd2;
    localparam logic [IDX_W-1:0] CFG_TRANSPOSE_SEMIS = 2'd3;

    localparam logic [1:0] VOICE_CLOSE  = 2'd0;
    localparam logic [1:0] VOICE_DROP2  = 2'd1;
    localparam logic [1:0] VOICE_DROP3  = 2'd2;
    localparam logic [1:0] VOICE_SPREAD = 2'd3;

    localparam logic [2:0] MODE_LOCRIAN = 3'd6;
    localparam logic [6:0] NOTE_MAX     = 7'd127;

    localparam logic signed [5:0] PLUS_OCT  = 6'sd12;
    localparam logic signed [5:0] MINUS_OCT = -6'sd12;

    localparam logic [1:0] QUALITY_OF [7][7] = '{
        '{2'd2, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3},
        '{2'd0, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd0},
        '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd0, 2'd0},
        '{2'd1, 2'd0, 2'd3, 2'd2, 2'd0, 2'd0, 2'd2},
        '{2'd0, 2'd3, 2'd2, 2'd0, 2'd0, 2'd2, 2'd1},
        '{2'd3, 2'd2, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0}
    };

    localparam logic signed [5:0] STEPS_OF [4][4] = '{
        '{6'sd0, 6'sd3, 6'sd7, 6'sd10},
        '{6'sd0, 6'sd4, 6'sd7, 6'sd10},
        '{6'sd0, 6'sd4, 6'sd7, 6'sd11},
        '{6'sd0, 6'sd3, 6'sd6, 6'sd10}
    };

    typedef struct packed {
        logic [NOTE_W-1:0] root_note;
        logic [DEG_W-1:0]  scale_degree;
    } t_in_item;

    typedef struct packed {
        logic [NOTE_W-1:0] note_root;
        logic [NOTE_W-1:0] note_third;
        logic [NOTE_W-1:0] note_fifth;
        logic [NOTE_W-1:0] note_seventh;
    } t_out_item;

    function automatic logic [NOTE_W-1:0] sat_add(
        input logic [NOTE_W-1:0] note,
        input logic signed [5:0] delta
    );
        logic signed [8:0] sum;
        begin
            sum = $signed({2'b00, note}) + 9'(delta);
            if (sum < 0) begin
                sat_add = '0;
            end else if (sum > 9'sd127) begin
                sat_add = NOTE_MAX;
            end else begin
                sat_add = sum[NOTE_W-1:0];
            end
        end
    endfunction

    // octal digit fold: 8 is 1 mod 7
    function automatic logic [2:0] mod7(input logic [DEG_W-1:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        begin
            s1 = {2'b00, x[2:0]} + {2'b00, x[5:3]} + {3'b000, x[7:6]};
            s2 = {1'b0, s1[2:0]} + {2'b00, s1[4:3]};
            if (s2 >= 4'd7) begin
                s2 = s2 - 4'd7;
            end
            mod7 = s2[2:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/diatonic_seventh_chord_voicer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// diatonic_seventh_chord_voicer
// Builds a voiced four-note seventh chord from a root note and scale degree.
//
// Usage: drive i_item and raise start; the item is taken at a rising edge
// where start is high and busy is low. busy stays low, so an item may be
// presented in every cycle. The item is held in an input register, the chord
// is formed by one pass of table lookups, saturating adds and tone ranking,
// and stored in the result register. o_valid rises at the edge after the
// accepting edge and marks o_result for one cycle. Throughput is one item
// per cycle. The receiver cannot stall: each result is shown for exactly
// one cycle.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 scale mode, 1 inversion, 2 voicing, 3 transpose); write only while idle.
// Reset (i_rst_n low, synchronous) clears the configuration registers and the
// valid flags, which drops any item in flight.
// ----------------------------------------------------------------------------

module diatonic_seventh_chord_voicer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire dscv_pkg::t_in_item             i_item,
    output logic                                o_valid,
    output dscv_pkg::t_out_item                 o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [dscv_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dscv_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [2:0]         r_scale_mode;
    logic [1:0]         r_inversion_sel;
    logic [1:0]         r_voicing_sel;
    logic signed [5:0]  r_transpose;

    logic                r_in_vld;
    dscv_pkg::t_in_item  r_in;
    logic                r_out_vld;
    dscv_pkg::t_out_item r_result;
    dscv_pkg::t_out_item n_result;

    logic [2:0]                   deg;
    logic [2:0]                   mode;
    logic [1:0]                   qual;
    logic [dscv_pkg::NOTE_W-1:0]  base_t [4];
    logic [dscv_pkg::NOTE_W-1:0]  inv_t  [4];
    logic [dscv_pkg::NOTE_W-1:0]  voc_t  [4];
    logic [dscv_pkg::NOTE_W-1:0]  fin_t  [4];
    logic [1:0]                   rank   [4];
    logic [1:0]                   want;
    logic                         found;

    assign busy     = 1'b0;
    assign o_valid  = r_out_vld;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_mode    <= '0;
            r_inversion_sel <= '0;
            r_voicing_sel   <= '0;
            r_transpose     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dscv_pkg::CFG_SCALE_MODE:      r_scale_mode    <= i_cfg_data[2:0];
                dscv_pkg::CFG_INVERSION_SEL:   r_inversion_sel <= i_cfg_data[1:0];
                dscv_pkg::CFG_VOICING_SEL:     r_voicing_sel   <= i_cfg_data[1:0];
                dscv_pkg::CFG_TRANSPOSE_SEMIS: r_transpose     <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        if (r_in_vld) begin
            r_result <= n_result;
        end
    end

    always_comb begin
        deg  = dscv_pkg::mod7(r_in.scale_degree);
        mode = (r_scale_mode > dscv_pkg::MODE_LOCRIAN) ? dscv_pkg::MODE_LOCRIAN
                                                      : r_scale_mode;
        qual = dscv_pkg::QUALITY_OF[mode][deg];

        for (int i = 0; i < 4; i++) begin
            base_t[i] = dscv_pkg::sat_add(r_in.root_note, dscv_pkg::STEPS_OF[qual][i]);
        end

        // raise the lowest tones
        for (int i = 0; i < 4; i++) begin
            if (i < 3 && 2'(i) < r_inversion_sel) begin
                inv_t[i] = dscv_pkg::sat_add(base_t[i], dscv_pkg::PLUS_OCT);
            end else begin
                inv_t[i] = base_t[i];
            end
        end

        for (int i = 0; i < 4; i++) begin
            rank[i] = 2'd0;
            for (int j = 0; j < 4; j++) begin
                if (j != i && inv_t[i] > inv_t[j]) begin
                    rank[i] = rank[i] + 2'd1;
                end
            end
        end

        want  = (r_voicing_sel == dscv_pkg::VOICE_DROP2) ? 2'd2 : 2'd1;
        found = 1'b0;
        voc_t = inv_t;
        case (r_voicing_sel)
            dscv_pkg::VOICE_DROP2, dscv_pkg::VOICE_DROP3: begin
                for (int i = 0; i < 4; i++) begin
                    if (!found && rank[i] == want) begin
                        voc_t[i] = dscv_pkg::sat_add(inv_t[i], dscv_pkg::MINUS_OCT);
                        found    = 1'b1;
                    end
                end
            end
            dscv_pkg::VOICE_SPREAD: begin
                for (int i = 1; i < 4; i++) begin
                    voc_t[i] = dscv_pkg::sat_add(inv_t[i], dscv_pkg::PLUS_OCT);
                end
            end
            default: ;
        endcase

        for (int i = 0; i < 4; i++) begin
            fin_t[i] = dscv_pkg::sat_add(voc_t[i], r_transpose);
        end

        n_result.note_root    = fin_t[0];
        n_result.note_third   = fin_t[1];
        n_result.note_fifth   = fin_t[2];
        n_result.note_seventh = fin_t[3];
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the diatonic seventh chord voicer.
//
// A table of directed chords covers the note and degree extremes, the
// inversions, each voicing with and without ties, the undefined mode and the
// full transpose range. Sixteen phases of random items follow, each under
// its own register setting. Expected chords come from the table or a local
// chord model; each strobed result is compared field by field, in order.
// ----------------------------------------------------------------------------

module tb_top;
    import dscv_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int DRAIN_WAIT  = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 100;
    localparam int QUIET_PHASE = 13;
    localparam int MAX_PRINTS  = 40;

    typedef enum int {Q_MIN7, Q_DOM7, Q_MAJ7, Q_HDIM7} chord_q_e;

    localparam chord_q_e MODE_QUALITY [7][7] = '{
        '{Q_MAJ7, Q_MIN7, Q_MIN7, Q_MAJ7, Q_DOM7, Q_MIN7, Q_HDIM7},
        '{Q_MIN7, Q_MIN7, Q_MAJ7, Q_DOM7, Q_MIN7, Q_HDIM7, Q_MAJ7},
        '{Q_MIN7, Q_MAJ7, Q_DOM7, Q_MIN7, Q_HDIM7, Q_MAJ7, Q_MIN7},
        '{Q_MAJ7, Q_DOM7, Q_MIN7, Q_HDIM7, Q_MAJ7, Q_MIN7, Q_MIN7},
        '{Q_DOM7, Q_MIN7, Q_HDIM7, Q_MAJ7, Q_MIN7, Q_MIN7, Q_MAJ7},
        '{Q_MIN7, Q_HDIM7, Q_MAJ7, Q_MIN7, Q_MIN7, Q_MAJ7, Q_DOM7},
        '{Q_HDIM7, Q_MAJ7, Q_MIN7, Q_MIN7, Q_MAJ7, Q_DOM7, Q_MIN7}
    };

    localparam int CHORD_STEPS [4][4] = '{
        '{0, 3, 7, 10},
        '{0, 4, 7, 10},
        '{0, 4, 7, 11},
        '{0, 3, 6, 10}
    };

    typedef struct {
        logic [2:0] mode;
        logic [1:0] inv;
        logic [1:0] voi;
        logic [5:0] shift;
        t_in_item   item;
        bit         typed;
        t_out_item  chord;
    } chord_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_item;
    logic                 o_valid;
    t_out_item            o_result;
    logic                 i_cfg_we;
    logic [IDX_W-1:0]     i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    logic [2:0]           mode_reg;
    logic [1:0]           inv_reg;
    logic [1:0]           voice_reg;
    logic signed [5:0]    shift_reg;

    t_out_item            pending_chords [$];
    chord_row_t           directed_rows [$];
    int                   mismatch_count;
    int                   chords_sent;
    int                   chords_checked;
    int                   settings_used;
    int                   cycle_count;

    diatonic_seventh_chord_voicer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int clamp_note(input int v);
        return (v < 0) ? 0 : ((v > 127) ? 127 : v);
    endfunction

    function automatic t_out_item voice_chord(input t_in_item it);
        int        tone [4];
        int        deg;
        int        md;
        int        want;
        int        rank;
        int        k;
        int        j;
        bit        dropped;
        chord_q_e  qual;
        t_out_item r;
        deg  = int'(it.scale_degree) % 7;
        md   = (mode_reg > MODE_LOCRIAN) ? int'(MODE_LOCRIAN) : int'(mode_reg);
        qual = MODE_QUALITY[md][deg];
        for (k = 0; k < 4; k++) begin
            tone[k] = clamp_note(int'(it.root_note) + CHORD_STEPS[qual][k]);
        end
        for (k = 0; k < int'(inv_reg) && k < 3; k++) begin
            tone[k] = clamp_note(tone[k] + 12);
        end
        if (voice_reg == VOICE_DROP2 || voice_reg == VOICE_DROP3) begin
            want    = (voice_reg == VOICE_DROP2) ? 2 : 1;
            dropped = 1'b0;
            for (k = 0; k < 4; k++) begin
                rank = 0;
                for (j = 0; j < 4; j++) begin
                    if (j != k && tone[k] > tone[j]) rank++;
                end
                if (!dropped && rank == want) begin
                    tone[k] = clamp_note(tone[k] - 12);
                    dropped = 1'b1;
                end
            end
        end else if (voice_reg == VOICE_SPREAD) begin
            for (k = 1; k < 4; k++) tone[k] = clamp_note(tone[k] + 12);
        end
        for (k = 0; k < 4; k++) tone[k] = clamp_note(tone[k] + int'(shift_reg));
        r.note_root    = 7'(tone[0]);
        r.note_third   = 7'(tone[1]);
        r.note_fifth   = 7'(tone[2]);
        r.note_seventh = 7'(tone[3]);
        return r;
    endfunction

    function automatic t_in_item pick_item();
        t_in_item it;
        case ($urandom_range(0, 9))
            0:       it.root_note = $urandom_range(0, 1) ? 7'd127 : 7'd0;
            1:       it.root_note = 7'($urandom_range(110, 127));
            2:       it.root_note = 7'($urandom_range(0, 12));
            default: it.root_note = 7'($urandom_range(0, 127));
        endcase
        it.scale_degree = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    task automatic add_row(input int mode, input int inv, input logic [1:0] voi,
                           input int shift, input int root, input int deg,
                           input bit typed, input int n0, input int n1,
                           input int n2, input int n3);
        chord_row_t row;
        row.mode               = 3'(mode);
        row.inv                = 2'(inv);
        row.voi                = voi;
        row.shift              = 6'(shift);
        row.item.root_note     = 7'(root);
        row.item.scale_degree  = 8'(deg);
        row.typed              = typed;
        row.chord.note_root    = 7'(n0);
        row.chord.note_third   = 7'(n1);
        row.chord.note_fifth   = 7'(n2);
        row.chord.note_seventh = 7'(n3);
        directed_rows.push_back(row);
    endtask

    // all tasks below are entered and left at a falling edge
    task automatic send_item(input t_in_item it, input t_out_item want);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_chords.push_back(want);
        chords_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_for(input int n);
        start  <= 1'b0;
        i_item <= pick_item();
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_chords.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [2:0] mode, input logic [1:0] inv,
                                input logic [1:0] voi, input logic [5:0] shift);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SCALE_MODE;
        i_cfg_data <= CFG_W'(mode);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_INVERSION_SEL;
        i_cfg_data <= CFG_W'(inv);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_VOICING_SEL;
        i_cfg_data <= CFG_W'(voi);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_TRANSPOSE_SEMIS;
        i_cfg_data <= shift;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        mode_reg   = mode;
        inv_reg    = inv;
        voice_reg  = voi;
        shift_reg  = shift;
        settings_used++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_chords.size() == 0) begin
                report_mismatch("result with nothing pending", int'(o_result), 0);
            end else begin
                automatic t_out_item want = pending_chords.pop_front();
                chords_checked++;
                if (o_result.note_root != want.note_root)
                    report_mismatch("note_root", int'(o_result.note_root),
                                    int'(want.note_root));
                if (o_result.note_third != want.note_third)
                    report_mismatch("note_third", int'(o_result.note_third),
                                    int'(want.note_third));
                if (o_result.note_fifth != want.note_fifth)
                    report_mismatch("note_fifth", int'(o_result.note_fifth),
                                    int'(want.note_fifth));
                if (o_result.note_seventh != want.note_seventh)
                    report_mismatch("note_seventh", int'(o_result.note_seventh),
                                    int'(want.note_seventh));
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int         phase;
        int         n;
        int         shift;
        bit         bursty;
        t_in_item   it;
        t_out_item  want;
        chord_row_t row;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        mode_reg       = '0;
        inv_reg        = '0;
        voice_reg      = VOICE_CLOSE;
        shift_reg      = '0;
        mismatch_count = 0;
        chords_sent    = 0;
        chords_checked = 0;
        settings_used  = 1;

        add_row(0, 0, VOICE_CLOSE,    0,  60,   0, 1,  60,  64,  67,  71);
        add_row(0, 0, VOICE_CLOSE,    0,   0,   0, 1,   0,   4,   7,  11);
        add_row(0, 0, VOICE_CLOSE,    0, 127, 255, 1, 127, 127, 127, 127);
        add_row(0, 0, VOICE_CLOSE,    0,  64,  13, 0,   0,   0,   0,   0);
        add_row(1, 0, VOICE_CLOSE,    0,  62,   1, 0,   0,   0,   0,   0);
        add_row(7, 0, VOICE_CLOSE,    0,  60,   0, 1,  60,  63,  66,  70);
        add_row(6, 0, VOICE_CLOSE,    0,  60,   7, 1,  60,  63,  66,  70);
        add_row(0, 0, VOICE_CLOSE,  -32,  10,   0, 1,   0,   0,   0,   0);
        add_row(0, 0, VOICE_CLOSE,   31, 127,   0, 1, 127, 127, 127, 127);
        add_row(0, 0, VOICE_CLOSE,   31,  60,   0, 1,  91,  95,  98, 102);
        add_row(0, 0, VOICE_CLOSE,  -24,  60,   0, 1,  36,  40,  43,  47);
        add_row(0, 0, VOICE_CLOSE,   24, 100,   0, 1, 124, 127, 127, 127);
        add_row(0, 1, VOICE_CLOSE,    0,  60,   0, 1,  72,  64,  67,  71);
        add_row(0, 3, VOICE_CLOSE,    0,  60,   0, 1,  72,  76,  79,  71);
        add_row(0, 0, VOICE_DROP2,    0,  60,   0, 1,  60,  64,  55,  71);
        add_row(0, 0, VOICE_DROP2,    0, 124,   0, 1, 124, 127, 127, 127);
        add_row(0, 0, VOICE_DROP3,    0,  60,   0, 1,  60,  52,  67,  71);
        add_row(0, 0, VOICE_DROP3,    0, 124,   0, 1, 124, 115, 127, 127);
        add_row(0, 0, VOICE_DROP3,    0, 127,   0, 1, 127, 127, 127, 127);
        add_row(0, 0, VOICE_SPREAD,   0,  60,   0, 1,  60,  76,  79,  83);
        add_row(0, 0, VOICE_SPREAD,   0, 120,   0, 1, 120, 127, 127, 127);
        add_row(3, 2, VOICE_DROP2,   -5,  55, 200, 0,   0,   0,   0,   0);
        add_row(5, 3, VOICE_SPREAD,  -1,   3,   4, 0,   0,   0,   0,   0);
        add_row(4, 2, VOICE_DROP3,   17, 117, 255, 0,   0,   0,   0,   0);
        add_row(2, 1, VOICE_DROP2,    0,   0, 128, 0,   0,   0,   0,   0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.mode != mode_reg || row.inv != inv_reg || row.voi != voice_reg ||
                row.shift != shift_reg) begin
                wait_drained();
                apply_config(row.mode, row.inv, row.voi, row.shift);
            end
            want = row.typed ? row.chord : voice_chord(row.item);
            send_item(row.item, want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: apply_config(3'd0, 2'd0, VOICE_CLOSE, 6'(-32));
                1: apply_config(3'd7, 2'd3, VOICE_SPREAD, 6'(31));
                2: apply_config(MODE_LOCRIAN, 2'd1, VOICE_DROP2, 6'(-24));
                3: apply_config(3'd3, 2'd2, VOICE_DROP3, 6'(24));
                default: begin
                    shift = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 63))
                                                        : int'($urandom_range(0, 48)) - 24;
                    apply_config(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                 2'($urandom_range(0, 3)), 6'(shift));
                end
            endcase
            bursty = (phase < QUIET_PHASE) && ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (bursty && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 15));
                it = pick_item();
                send_item(it, voice_chord(it));
            end
        end

        wait_drained();
        $display("Sent %0d chords under %0d register settings; %0d results checked",
                 chords_sent, settings_used, chords_checked);
        $display("Covered all modes incl. the undefined one, every inversion and voicing");
        if (mismatch_count == 0 && pending_chords.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/dscv_pkg.sv
rtl/core/diatonic_seventh_chord_voicer.sv
tb/sv/tb_top.sv
